// ----- hw/rtl/magic_framed_message_receiver_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the framed message receiver
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MAGIC_FRAMED_MESSAGE_RECEIVER_TOP_ASSERT_SVH
`define MAGIC_FRAMED_MESSAGE_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication
`define MFMR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MFMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mfmr_pkg.sv -----
// ----------------------------------------------------------------------------
// mfmr_pkg
// Shared types, constants and the final status check of the frame receiver.
// ----------------------------------------------------------------------------
package mfmr_pkg;

  // Header layout
  localparam int unsigned HdrBytes   = 12;
  localparam int unsigned FillW      = 4;
  localparam int unsigned MaxPayload = 512;

  // Configuration register indexes
  localparam logic [1:0] CfgIdxMagic   = 2'd0;
  localparam logic [1:0] CfgIdxVersion = 2'd1;
  localparam logic [1:0] CfgIdxLimit   = 2'd2;

  // Configuration reset values
  localparam logic [31:0] ResetMagic   = 32'h4652_4F53;
  localparam logic [7:0]  ResetVersion = 8'h01;
  localparam logic [9:0]  ResetLimit   = 10'd512;

  // Message type codes
  localparam logic [7:0] TypeShare   = 8'h01;
  localparam logic [7:0] TypePubKey  = 8'h02;
  localparam logic [7:0] TypeCommit  = 8'h03;
  localparam logic [7:0] TypeEnd     = 8'hFF;

  // Required payload sizes
  localparam logic [15:0] ShareBytes     = 16'd36;
  localparam logic [15:0] PubKeyBytes    = 16'd136;
  localparam logic [15:0] CommitMinBytes = 16'd104;

  typedef enum logic [2:0] {
    StatusOk          = 3'd0,
    StatusBadVersion  = 3'd1,
    StatusTooLong     = 3'd2,
    StatusUnknownType = 3'd3,
    StatusBadSize     = 3'd4
  } status_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [7:0]  version;
    logic [9:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic        has_result;
    logic        has_data;
    logic [7:0]  data_byte;
    logic [8:0]  byte_offset;
    logic        end_of_message;
    logic [7:0]  message_type;
    logic [31:0] participant_id;
    logic [15:0] payload_length;
    status_e     status;
  } res_t;

  // Check the payload size against the message type
  function automatic status_e final_status(logic [7:0] type_code, logic [15:0] len);
    status_e st;
    case (type_code)
      TypeShare:  st = (len == ShareBytes)      ? StatusOk : StatusBadSize;
      TypePubKey: st = (len == PubKeyBytes)     ? StatusOk : StatusBadSize;
      TypeCommit: st = (len >= CommitMinBytes)  ? StatusOk : StatusBadSize;
      TypeEnd:    st = StatusOk;
      default:    st = StatusUnknownType;
    endcase
    return st;
  endfunction

endpackage

// ----- hw/rtl/mfmr_cfg.sv -----
// ----------------------------------------------------------------------------
// mfmr_cfg
// Configuration registers: sync magic, protocol version and payload limit.
// ----------------------------------------------------------------------------
module mfmr_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  output mfmr_pkg::cfg_t     cfg_o
);

  mfmr_pkg::cfg_t cfg_q;

  // Write the addressed register; drop writes to unused indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic   <= mfmr_pkg::ResetMagic;
      cfg_q.version <= mfmr_pkg::ResetVersion;
      cfg_q.limit   <= mfmr_pkg::ResetLimit;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mfmr_pkg::CfgIdxMagic:   cfg_q.magic   <= cfg_wdata_i;
        mfmr_pkg::CfgIdxVersion: cfg_q.version <= cfg_wdata_i[7:0];
        mfmr_pkg::CfgIdxLimit:   cfg_q.limit   <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/mfmr_frame.sv -----
// ----------------------------------------------------------------------------
// mfmr_frame
// Header window, header checks and payload pass-through for one byte a cycle while proc_i is high.
// ----------------------------------------------------------------------------
`include "magic_framed_message_receiver_top_assert.svh"

module mfmr_frame (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            proc_i,
  input  logic [7:0]      byte_i,
  input  mfmr_pkg::cfg_t  cfg_i,
  output mfmr_pkg::res_t  res_o
);

  localparam int unsigned LastIdx = mfmr_pkg::HdrBytes - 1;
  localparam logic [mfmr_pkg::FillW-1:0] FillFull = mfmr_pkg::FillW'(LastIdx);
  localparam logic [16:0] MaxPayloadW = 17'(mfmr_pkg::MaxPayload);

  logic [7:0]  window_q [mfmr_pkg::HdrBytes];
  logic [7:0]  shifted  [mfmr_pkg::HdrBytes];
  logic [mfmr_pkg::FillW-1:0] fill_q, fill_d;
  logic        in_payload_q, in_payload_d;
  logic [9:0]  bytes_q, bytes_d;
  logic [7:0]  held_type_q, held_type_d;
  logic [15:0] held_len_q, held_len_d;
  logic [31:0] held_part_q, held_part_d;

  logic [31:0] magic;
  logic [7:0]  version;
  logic [15:0] hdr_len;
  logic [16:0] limit;
  logic [9:0]  bytes_inc;
  mfmr_pkg::res_t res;

  // Shift the new byte in at the top of the window
  always_comb begin
    for (int i = 0; i < LastIdx; i++) begin
      shifted[i] = window_q[i+1];
    end
    shifted[LastIdx] = byte_i;
  end

  assign magic   = {shifted[3], shifted[2], shifted[1], shifted[0]};
  assign version = shifted[4];
  assign hdr_len = {shifted[7], shifted[6]};
  assign limit   = ({7'b0, cfg_i.limit} > MaxPayloadW) ? MaxPayloadW
                                                        : {7'b0, cfg_i.limit};
  assign bytes_inc = bytes_q + 10'd1;

  // Decide the next state and the result for this byte
  always_comb begin
    fill_d       = fill_q;
    in_payload_d = in_payload_q;
    bytes_d      = bytes_q;
    held_type_d  = held_type_q;
    held_len_d   = held_len_q;
    held_part_d  = held_part_q;

    res                = '0;
    res.status         = mfmr_pkg::StatusOk;

    if (in_payload_q) begin
      // Pass a payload byte through, close the message on the last one
      bytes_d            = bytes_inc;
      res.has_result     = 1'b1;
      res.has_data       = 1'b1;
      res.data_byte      = byte_i;
      res.byte_offset    = bytes_q[8:0];
      if ({6'b0, bytes_inc} >= held_len_q) begin
        in_payload_d       = 1'b0;
        res.end_of_message = 1'b1;
        res.status         = mfmr_pkg::final_status(held_type_q, held_len_q);
      end
    end else if (fill_q != FillFull) begin
      // Collect header bytes
      fill_d = fill_q + 1'b1;
    end else if (magic == cfg_i.magic) begin
      // Full header with good magic: latch fields and check them
      fill_d      = '0;
      held_type_d = shifted[5];
      held_len_d  = hdr_len;
      held_part_d = {shifted[11], shifted[10], shifted[9], shifted[8]};
      if (version != cfg_i.version) begin
        res.has_result     = 1'b1;
        res.end_of_message = 1'b1;
        res.status         = mfmr_pkg::StatusBadVersion;
      end else if ({1'b0, hdr_len} > limit) begin
        res.has_result     = 1'b1;
        res.end_of_message = 1'b1;
        res.status         = mfmr_pkg::StatusTooLong;
      end else if (hdr_len == 16'd0) begin
        res.has_result     = 1'b1;
        res.end_of_message = 1'b1;
        res.status         = mfmr_pkg::final_status(shifted[5], 16'd0);
      end else begin
        in_payload_d = 1'b1;
        bytes_d      = '0;
      end
    end
    // Wrong magic: the oldest byte falls out with the shift, fill holds

    res.message_type   = held_type_d;
    res.participant_id = held_part_d;
    res.payload_length = held_len_d;
  end

  // Advance state when the byte is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      in_payload_q <= 1'b0;
      bytes_q      <= '0;
      held_type_q  <= '0;
      held_len_q   <= '0;
      held_part_q  <= '0;
    end else if (proc_i) begin
      fill_q       <= fill_d;
      in_payload_q <= in_payload_d;
      bytes_q      <= bytes_d;
      held_type_q  <= held_type_d;
      held_len_q   <= held_len_d;
      held_part_q  <= held_part_d;
    end
  end

  // Header window shifts in only bytes outside the payload
  always_ff @(posedge clk_i) begin
    if (proc_i && !in_payload_q) begin
      window_q <= shifted;
    end
  end

  assign res_o = res;

  `MFMR_ASSERT_IMP(a_fill_range, clk_i, rst_ni, 1'b1, fill_q <= FillFull, "fill out of range")
  `MFMR_ASSERT_IMP(a_payload_len, clk_i, rst_ni, in_payload_q, {6'b0, bytes_q} < held_len_q, "payload past length")
  `MFMR_ASSERT_IMP(a_payload_fill, clk_i, rst_ni, in_payload_q, fill_q == '0, "window not cleared in payload")

endmodule

// ----- hw/rtl/magic_framed_message_receiver_top.sv -----
// Flow: a byte is taken into the input register, decided by the frame logic while
// it sits there, and its result (if any) is loaded into the result register and shown.
// Throughput: one byte per cycle; a byte waits in the input register only while
// the result register is held by a stall, set by the single decision stage.
// Reset: asynchronous, active low; clears the header fill count, payload state
// and held header fields, and loads the config reset values.
// ----------------------------------------------------------------------------
// magic_framed_message_receiver_top
// Magic-word framed message receiver: header sync, checks and payload pass.
// ----------------------------------------------------------------------------
`include "magic_framed_message_receiver_top_assert.svh"

module magic_framed_message_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // byte requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // result requests
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        has_data_o,
  output logic [7:0]  data_byte_o,
  output logic [8:0]  byte_offset_o,
  output logic        end_of_message_o,
  output logic [7:0]  message_type_o,
  output logic [31:0] participant_id_o,
  output logic [15:0] payload_length_o,
  output logic [2:0]  status_o
);

  mfmr_pkg::cfg_t cfg;
  mfmr_pkg::res_t res;
  mfmr_pkg::res_t res_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       out_blocked;
  logic       advance;
  logic       accept;

  mfmr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mfmr_frame u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .proc_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Hold the input request only while the result register is held
  assign out_blocked = out_valid_q && out_stall_i;
  assign advance     = in_valid_q && !out_blocked;
  assign in_stall_o  = in_valid_q && out_blocked;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.has_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.has_result) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign has_data_o       = res_q.has_data;
  assign data_byte_o      = res_q.data_byte;
  assign byte_offset_o    = res_q.byte_offset;
  assign end_of_message_o = res_q.end_of_message;
  assign message_type_o   = res_q.message_type;
  assign participant_id_o = res_q.participant_id;
  assign payload_length_o = res_q.payload_length;
  assign status_o         = res_q.status;

  `MFMR_ASSERT_IMP(a_stall_needs_result, clk_i, rst_ni, in_stall_o, out_valid_q, "input held with empty result register")
  `MFMR_ASSERT_IMP(a_nodata_is_final, clk_i, rst_ni, out_valid_q && !res_q.has_data, res_q.end_of_message, "result without data is not final")
  `MFMR_ASSERT_IMP(a_midmsg_ok, clk_i, rst_ni, out_valid_q && !res_q.end_of_message, res_q.status == mfmr_pkg::StatusOk, "status set before end of message")
  `MFMR_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, advance && res.has_result, out_valid_q, "result lost")

endmodule

// ----- tb/sv/magic_framed_message_receiver_checker.sv -----
// ----------------------------------------------------------------------------
// Framed message receiver checker
// Tracks register writes and accepted bytes, works out the results they cause
// and compares each accepted result with the oldest one still awaited.
// ----------------------------------------------------------------------------
module magic_framed_message_receiver_checker
  import mfmr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        has_data_i,
  input  logic [7:0]  data_byte_i,
  input  logic [8:0]  byte_offset_i,
  input  logic        end_of_message_i,
  input  logic [7:0]  message_type_i,
  input  logic [31:0] participant_id_i,
  input  logic [15:0] payload_length_i,
  input  logic [2:0]  status_i,
  output int          mismatches_o,
  output int          awaited_o,
  output int          checked_o,
  output int          closed_o,
  output logic        in_body_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        has_data;
    logic [7:0]  data_byte;
    logic [8:0]  byte_offset;
    logic        end_of_message;
    logic [7:0]  message_type;
    logic [31:0] participant_id;
    logic [15:0] payload_length;
    status_e     status;
  } rx_result_t;

  // Register copies
  logic [31:0] sync_word;
  logic [7:0]  accepted_version;
  logic [9:0]  length_cap;

  // Receiver state
  logic        in_body;
  logic [7:0]  hdr_win [HdrBytes];
  int unsigned hdr_fill;
  logic [9:0]  body_count;
  logic [7:0]  held_type;
  logic [15:0] held_len;
  logic [31:0] held_part;

  rx_result_t  awaited_results [$];

  // Judge the payload size against the message type
  function automatic status_e size_verdict(logic [7:0] type_code, logic [15:0] len);
    status_e verdict;
    verdict = StatusUnknownType;
    if (type_code == TypeEnd) verdict = StatusOk;
    else if (type_code == TypeShare) verdict = (len == ShareBytes) ? StatusOk : StatusBadSize;
    else if (type_code == TypePubKey) verdict = (len == PubKeyBytes) ? StatusOk : StatusBadSize;
    else if (type_code == TypeCommit)
      verdict = (len >= CommitMinBytes) ? StatusOk : StatusBadSize;
    return verdict;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches_o < 200)
      $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches_o++;
  endtask

  // Advance the receiver by one byte and queue the result it causes
  task automatic track_rx_byte(logic [7:0] b);
    rx_result_t  r;
    logic [31:0] magic;
    logic [7:0]  version;
    int unsigned eff_limit;
    r = '0;
    if (in_body) begin
      r.has_data       = 1'b1;
      r.data_byte      = b;
      r.byte_offset    = body_count[8:0];
      r.message_type   = held_type;
      r.participant_id = held_part;
      r.payload_length = held_len;
      r.status         = StatusOk;
      body_count       = body_count + 10'd1;
      if ({6'd0, body_count} >= held_len) begin
        in_body          = 1'b0;
        r.end_of_message = 1'b1;
        r.status         = size_verdict(held_type, held_len);
      end
      awaited_results.push_back(r);
    end else begin
      if (hdr_fill >= HdrBytes) hdr_fill = HdrBytes - 1;
      hdr_win[hdr_fill] = b;
      hdr_fill++;
      if (hdr_fill == HdrBytes) begin
        magic = {hdr_win[3], hdr_win[2], hdr_win[1], hdr_win[0]};
        if (magic != sync_word) begin
          // drop the oldest byte and hunt on
          for (int k = 0; k < HdrBytes - 1; k++) hdr_win[k] = hdr_win[k + 1];
          hdr_win[HdrBytes - 1] = 8'h00;
          hdr_fill = HdrBytes - 1;
        end else begin
          version   = hdr_win[4];
          held_type = hdr_win[5];
          held_len  = {hdr_win[7], hdr_win[6]};
          held_part = {hdr_win[11], hdr_win[10], hdr_win[9], hdr_win[8]};
          hdr_fill  = 0;
          for (int k = 0; k < HdrBytes; k++) hdr_win[k] = 8'h00;
          eff_limit = (length_cap > MaxPayload) ? MaxPayload : length_cap;
          r.end_of_message = 1'b1;
          r.message_type   = held_type;
          r.participant_id = held_part;
          r.payload_length = held_len;
          if (version != accepted_version) begin
            r.status = StatusBadVersion;
            awaited_results.push_back(r);
          end else if (held_len > eff_limit) begin
            r.status = StatusTooLong;
            awaited_results.push_back(r);
          end else if (held_len == 16'd0) begin
            r.status = size_verdict(held_type, held_len);
            awaited_results.push_back(r);
          end else begin
            in_body    = 1'b1;
            body_count = 10'd0;
          end
        end
      end
    end
  endtask

  // Compare one accepted result with the oldest awaited one
  task automatic check_result();
    rx_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with nothing awaited", {29'd0, status_i}, 32'd0);
    end else begin
      want = awaited_results.pop_front();
      if (has_data_i !== want.has_data)
        report_mismatch("has_data", 32'(has_data_i), 32'(want.has_data));
      if (data_byte_i !== want.data_byte)
        report_mismatch("data_byte", 32'(data_byte_i), 32'(want.data_byte));
      if (byte_offset_i !== want.byte_offset)
        report_mismatch("byte_offset", 32'(byte_offset_i), 32'(want.byte_offset));
      if (end_of_message_i !== want.end_of_message)
        report_mismatch("end_of_message", 32'(end_of_message_i), 32'(want.end_of_message));
      if (message_type_i !== want.message_type)
        report_mismatch("message_type", 32'(message_type_i), 32'(want.message_type));
      if (participant_id_i !== want.participant_id)
        report_mismatch("participant_id", participant_id_i, want.participant_id);
      if (payload_length_i !== want.payload_length)
        report_mismatch("payload_length", 32'(payload_length_i), 32'(want.payload_length));
      if (status_i !== want.status)
        report_mismatch("status", 32'(status_i), 32'(want.status));
      checked_o++;
      if (want.end_of_message) closed_o++;
    end
  endtask

  // Register writes, result checks and byte tracking on each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word        = ResetMagic;
      accepted_version = ResetVersion;
      length_cap       = ResetLimit;
      in_body          = 1'b0;
      hdr_fill         = 0;
      body_count       = 10'd0;
      held_type        = 8'h00;
      held_len         = 16'd0;
      held_part        = 32'd0;
      for (int k = 0; k < HdrBytes; k++) hdr_win[k] = 8'h00;
      awaited_results.delete();
      mismatches_o = 0;
      checked_o    = 0;
      closed_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgIdxMagic:   sync_word = cfg_wdata_i;
          CfgIdxVersion: accepted_version = cfg_wdata_i[7:0];
          CfgIdxLimit:   length_cap = cfg_wdata_i[9:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) track_rx_byte(rx_byte_i);
    end
    awaited_o = awaited_results.size();
    in_body_o = in_body;
  end

endmodule

// ----- tb/sv/magic_framed_message_receiver_top_test.sv -----
// ----------------------------------------------------------------------------
// Framed message receiver testbench
// Feeds header and payload byte streams under four register settings, with
// bursty input and a stalling output, and leaves the checking to the checker.
// ----------------------------------------------------------------------------
module magic_framed_message_receiver_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mfmr_pkg::*;

  typedef enum int {
    FrameShare, FramePubKey, FrameCommit, FrameEnd, FrameUnknown,
    FrameBadVersion, FrameTooLong, FrameNoise, FrameCut
  } frame_kind_e;

  typedef enum int {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = CfgIdxMagic;
  logic [31:0] cfg_wdata = 32'd0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        has_data;
  logic [7:0]  data_byte;
  logic [8:0]  byte_offset;
  logic        end_of_message;
  logic [7:0]  message_type;
  logic [31:0] participant_id;
  logic [15:0] payload_length;
  logic [2:0]  status;

  int   mismatches, awaited, checked, closed;
  logic in_body;

  // Stimulus bookkeeping
  int          burst_left     = 0;
  bit          gaps_on        = 1'b1;
  int          bytes_sent     = 0;
  int          sequences_sent = 0;
  int          holds_asked    = 0;
  logic [31:0] cur_magic      = ResetMagic;
  logic [7:0]  cur_version    = ResetVersion;
  logic [9:0]  cur_limit      = ResetLimit;

  magic_framed_message_receiver_top DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .has_data_o       (has_data),
    .data_byte_o      (data_byte),
    .byte_offset_o    (byte_offset),
    .end_of_message_o (end_of_message),
    .message_type_o   (message_type),
    .participant_id_o (participant_id),
    .payload_length_o (payload_length),
    .status_o         (status)
  );

  magic_framed_message_receiver_checker rx_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .has_data_i       (has_data),
    .data_byte_i      (data_byte),
    .byte_offset_i    (byte_offset),
    .end_of_message_i (end_of_message),
    .message_type_i   (message_type),
    .participant_id_i (participant_id),
    .payload_length_i (payload_length),
    .status_i         (status),
    .mismatches_o     (mismatches),
    .awaited_o        (awaited),
    .checked_o        (checked),
    .closed_o         (closed),
    .in_body_o        (in_body)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Offer one byte request, with a random gap between bursts, and hold it until taken
  task automatic send_byte(logic [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid = 1'b1;
    rx_byte  = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drain every awaited result, then let the pipeline settle
  task automatic wait_idle();
    release_input();
    while (awaited != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Push filler bytes until the block is back to hunting for a header
  task automatic leave_payload();
    release_input();
    while (in_body) begin
      send_byte(8'($urandom));
      release_input();
    end
  endtask

  // Send the first hdr_bytes header bytes, little-endian, then body_bytes of payload
  task automatic send_frame(logic [31:0] magic, logic [7:0] version, logic [7:0] type_code,
                            logic [15:0] len, logic [31:0] participant,
                            int hdr_bytes, int body_bytes);
    logic [95:0] hdr;
    hdr = {participant, len, type_code, version, magic};
    for (int i = 0; i < hdr_bytes; i++) send_byte(hdr[8*i +: 8]);
    for (int i = 0; i < body_bytes; i++) send_byte(8'($urandom));
    sequences_sent++;
  endtask

  // Frames of every type, some with wrong sizes, plus unknown types, bad versions, noise and broken headers
  task automatic send_random_frame();
    frame_kind_e kind;
    logic [7:0]  version;
    logic [7:0]  type_code;
    logic [15:0] len;
    int          eff_limit;
    int          hdr_bytes;
    int          body_bytes;
    kind       = frame_kind_e'($urandom_range(int'(FrameShare), int'(FrameCut)));
    version    = cur_version;
    type_code  = TypeEnd;
    len        = 16'd0;
    hdr_bytes  = HdrBytes;
    body_bytes = 0;
    eff_limit  = (cur_limit > MaxPayload) ? MaxPayload : cur_limit;
    gaps_on    = ($urandom_range(0, 3) != 0);
    case (kind)
      FrameShare: begin
        type_code = TypeShare;
        len = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 40)) : ShareBytes;
      end
      FramePubKey: begin
        type_code = TypePubKey;
        len = ($urandom_range(0, 1) == 0) ? PubKeyBytes : 16'($urandom_range(0, 12));
      end
      FrameCommit: begin
        type_code = TypeCommit;
        len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(104, 112))
                                          : 16'($urandom_range(0, 10));
      end
      FrameEnd: len = 16'($urandom_range(0, 8));
      FrameUnknown: begin
        do type_code = 8'($urandom);
        while (type_code == TypeShare || type_code == TypePubKey ||
               type_code == TypeCommit || type_code == TypeEnd);
        len = 16'($urandom_range(0, 6));
      end
      FrameBadVersion: begin
        version   = cur_version ^ 8'($urandom_range(1, 255));
        type_code = 8'($urandom);
        len       = 16'($urandom);
      end
      FrameTooLong: begin
        type_code = 8'($urandom);
        len       = 16'($urandom_range(eff_limit + 1, 65535));
      end
      FrameNoise: begin
        hdr_bytes  = 0;
        body_bytes = $urandom_range(1, 14);
      end
      FrameCut: begin
        hdr_bytes = $urandom_range(1, HdrBytes - 1);
        type_code = 8'($urandom);
        len       = 16'($urandom_range(0, 20));
      end
      default: ;
    endcase
    if (kind <= FrameUnknown) body_bytes = len;
    send_frame(cur_magic, version, type_code, len, $urandom, hdr_bytes, body_bytes);
  endtask

  // New register setting, then a stretch of random frames
  task automatic run_phase(logic [31:0] magic, logic [7:0] version, logic [9:0] limit,
                           int n_bytes);
    int target;
    wait_idle();
    write_reg(CfgIdxMagic, magic);
    write_reg(CfgIdxVersion, {24'd0, version});
    write_reg(CfgIdxLimit, {22'd0, limit});
    cur_magic   = magic;
    cur_version = version;
    cur_limit   = limit;
    leave_payload();
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) send_random_frame();
  endtask

  // Result side: stall patterns, plus long hold-offs on request
  initial begin : result_side
    int          hold_left;
    int          mode_left;
    int          holds_served;
    stall_mode_e mode;
    hold_left    = 0;
    mode_left    = 0;
    holds_served = 0;
    mode         = StallNone;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(int'(StallNone), int'(StallPeriodic)));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          StallNone:     out_stall = 1'b0;
          StallLight:    out_stall = ($urandom_range(0, 99) < 30);
          StallHeavy:    out_stall = ($urandom_range(0, 99) < 75);
          StallPeriodic: out_stall = (mode_left % 3 == 0);
          default:       out_stall = 1'b0;
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int target;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Leading junk byte, then an empty end message, then a header whose
    // version and length are both bad
    gaps_on = 1'b0;
    send_byte(8'hFF);
    send_frame(ResetMagic, ResetVersion, TypeEnd, 16'd0, 32'hFFFF_FFFF, HdrBytes, 0);
    send_frame(ResetMagic, 8'h00, TypeShare, 16'hFFFF, 32'h0000_0000, HdrBytes, 0);

    // Random frames at the reset setting
    gaps_on = 1'b1;
    target  = bytes_sent + 40;
    while (bytes_sent < target) send_random_frame();

    run_phase($urandom, 8'($urandom), 10'($urandom_range(40, 200)), 30);
    run_phase(32'h0000_0000, 8'h00, 10'd0, 20);
    run_phase(32'hFFFF_FFFF, 8'hFF, 10'(MaxPayload), 20);

    // Longest payload while the result side holds off, then one byte too long
    leave_payload();
    send_frame(cur_magic, cur_version, TypeCommit, 16'(MaxPayload), $urandom, HdrBytes, 0);
    holds_asked++;
    repeat (MaxPayload) send_byte(8'($urandom));
    send_frame(cur_magic, cur_version, TypeCommit, 16'(MaxPayload + 1), $urandom,
               HdrBytes, 0);

    wait_idle();
    repeat (8) @(negedge clk);
    $display("Sent %0d bytes in %0d frames and fragments under four register settings.",
             bytes_sent, sequences_sent);
    $display("Checked %0d results, %0d of them closing or rejecting a message.",
             checked, closed);
    if (mismatches == 0) begin
      $display("** magic_framed_message_receiver_top: PASSED **");
    end else begin
      $display("** magic_framed_message_receiver_top: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #2_000_000;
    $display("** magic_framed_message_receiver_top: FAILED **");
    $finish;
  end

endmodule
